@@ hdl/pbrd_pkg.sv @@
// Shared types and constants for the PackBits row decoder.
package pbrd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_COMPRESSED   = 2'd2
	} pbrd_reg_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LITERAL = 2'd1,
		PH_REPEAT  = 2'd2
	} pbrd_phase_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [15:0] image_height;
		logic        compressed;
	} pbrd_cfg_t;

	// One queued byte with its header classification worked out up front.
	typedef struct packed {
		logic [7:0] body_byte;
		logic       lit;
		logic [7:0] len;
	} pbrd_entry_t;

	typedef struct packed {
		logic        overrun;
		logic        image_end;
		logic        row_end;
		logic [7:0]  copies;
		logic [9:0]  column;
		logic [15:0] row;
		logic [7:0]  pixel;
	} pbrd_result_t;

endpackage

@@ hdl/pbrd_front.sv @@
// Front end: accepts body bytes, classifies them as headers, and queues them.
module pbrd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	output logic                 q_valid,
	input  logic                 q_ready,
	output pbrd_pkg::pbrd_entry_t q_entry
);

	localparam int unsigned CW = pbrd_pkg::QUEUE_AW + 1;

	pbrd_pkg::pbrd_entry_t       mem_q [pbrd_pkg::QUEUE_DEPTH];
	logic [pbrd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [pbrd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [CW-1:0]               count_q;
	logic                        push;
	logic                        pop;
	pbrd_pkg::pbrd_entry_t       new_entry;

	assign in_ready = (count_q != CW'(pbrd_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_entry  = mem_q[rd_ptr_q];

	// Header view: 1..127 opens a literal run of b+1 bytes, else a repeat of 257-b (0 -> 1).
	always_comb begin
		new_entry.body_byte = in_byte;
		new_entry.lit       = (in_byte != 8'd0) && !in_byte[7];
		if (new_entry.lit) begin
			new_entry.len = in_byte + 8'd1;
		end else if (in_byte == 8'd0) begin
			new_entry.len = 8'd1;
		end else begin
			new_entry.len = 8'd1 - in_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/pbrd_decode.sv @@
// Back end: row/run decoder state and the registered result stage.
module pbrd_decode #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbrd_pkg::pbrd_cfg_t   cfg,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  pbrd_pkg::pbrd_entry_t q_entry,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pbrd_pkg::pbrd_result_t res
);

	localparam int unsigned PW  = $clog2(MAX_WIDTH + 2);
	localparam int unsigned EW0 = $clog2(MAX_WIDTH + 131);
	localparam int unsigned EW  = (EW0 > 12) ? EW0 : 12;
	localparam logic [EW-1:0] WMAX = EW'(MAX_WIDTH);

	pbrd_pkg::pbrd_phase_t phase_q, phase_d;
	logic [7:0]    ll_q, ll_d, ll_dec;
	logic [7:0]    rl_q, rl_d;
	logic [PW-1:0] pos_q;
	logic [15:0]   row_q, row_d;
	logic          out_valid_q;
	pbrd_pkg::pbrd_result_t out_q;

	logic [EW-1:0] wid_e, vis, pad, pos_e, end_e, npos_e, left_e;
	logic [16:0]   h_e, row_inc;
	logic          take, emit, rend, ovr, iend;
	logic [7:0]    cnt;

	assign q_ready   = !out_valid_q || res_ready;
	assign take      = q_valid && q_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	assign wid_e  = EW'(cfg.image_width);
	assign vis    = (wid_e == '0) ? EW'(1) : ((wid_e > WMAX) ? WMAX : wid_e);
	assign pad    = vis + EW'(vis[0]);
	assign pos_e  = EW'(pos_q);
	assign end_e  = pos_e + EW'(rl_q);
	assign left_e = vis - pos_e;
	assign ll_dec = (ll_q != 8'd0) ? (ll_q - 8'd1) : 8'd0;
	assign h_e    = (cfg.image_height == 16'd0) ? 17'd1 : {1'b0, cfg.image_height};
	assign row_inc = {1'b0, row_q} + 17'd1;
	assign iend   = (row_inc >= h_e);

	// Next phase.
	always_comb begin
		if (!cfg.compressed) begin
			phase_d = pbrd_pkg::PH_HEADER;
		end else begin
			unique case (phase_q)
				pbrd_pkg::PH_LITERAL: begin
					phase_d = (ll_dec == 8'd0) ? pbrd_pkg::PH_HEADER : pbrd_pkg::PH_LITERAL;
				end
				pbrd_pkg::PH_REPEAT: begin
					phase_d = pbrd_pkg::PH_HEADER;
				end
				default: begin
					phase_d = q_entry.lit ? pbrd_pkg::PH_LITERAL : pbrd_pkg::PH_REPEAT;
				end
			endcase
		end
	end

	// Run counters, position and the result event.
	always_comb begin
		ll_d   = ll_q;
		rl_d   = rl_q;
		npos_e = pos_e;
		rend   = 1'b0;
		ovr    = 1'b0;
		cnt    = 8'd0;
		if (!cfg.compressed) begin
			ll_d   = 8'd0;
			cnt    = {7'd0, pos_e < vis};
			npos_e = (pos_e < pad) ? (pos_e + EW'(1)) : pos_e;
			rend   = (npos_e >= pad);
		end else begin
			unique case (phase_q)
				pbrd_pkg::PH_LITERAL: begin
					ll_d   = ll_dec;
					cnt    = {7'd0, pos_e < vis};
					npos_e = (pos_e >= pad) ? pos_e : (pos_e + EW'(1));
					if (ll_dec == 8'd0) begin
						if (pos_e >= pad) begin
							cnt  = 8'd0;
							rend = 1'b1;
							ovr  = 1'b1;
						end else begin
							rend = (npos_e >= pad);
						end
					end
				end
				pbrd_pkg::PH_REPEAT: begin
					if (pos_e < vis) begin
						cnt = (left_e > EW'(rl_q)) ? rl_q : left_e[7:0];
					end
					npos_e = (end_e < pad) ? end_e : pad;
					rend   = (end_e >= pad);
					ovr    = (end_e > pad);
				end
				default: begin
					if (q_entry.lit) begin
						ll_d = q_entry.len;
					end else begin
						rl_d = q_entry.len;
					end
				end
			endcase
		end
		emit = rend || (cnt != 8'd0);
		row_d = row_q;
		if (rend) begin
			ll_d   = 8'd0;
			npos_e = '0;
			row_d  = iend ? 16'd0 : row_inc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pbrd_pkg::PH_HEADER;
			ll_q        <= 8'd0;
			rl_q        <= 8'd0;
			pos_q       <= '0;
			row_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= rend ? pbrd_pkg::PH_HEADER : phase_d;
				ll_q    <= ll_d;
				rl_q    <= rl_d;
				pos_q   <= npos_e[PW-1:0];
				row_q   <= row_d;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q.pixel     <= q_entry.body_byte;
			out_q.row       <= row_q;
			out_q.column    <= (cnt != 8'd0) ? pos_e[9:0] : 10'd0;
			out_q.copies    <= cnt;
			out_q.row_end   <= rend;
			out_q.image_end <= rend && iend;
			out_q.overrun   <= ovr;
		end
	end

endmodule

@@ hdl/packbits_row_decoder_unit.sv @@
// Top level of the PackBits row decoder: config registers, front queue and decoder.
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries bitmap body bytes, one per
//   transfer. The master stream carries one write command per result: a pixel value,
//   its row, a first column and a count of visible copies; m_tlast marks the result
//   that finishes a row, m_tuser flags the end of the image and a run overrun.
//   Header bytes and dropped bytes that do not end a row produce no transfer on the
//   master side.
//   The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes image_width
//   (index 0), image_height (index 1) and compressed (index 2); cfg_ready is always
//   high. Write it only while the decoder is idle.
// Timing:
//   A byte runs through a four-entry front queue into the decoder; its result, if any,
//   passes through the queue and then the output register before it can transfer on
//   the master side. The decoder retires one byte per cycle while the output register
//   is empty or m_tready is high.
// Reset and stalls:
//   Reset empties the queue and output register, returns to header phase at row 0
//   column 0 and loads width 320, height 200, compressed mode. While m_tready is low
//   the result holds in the output register and input bytes keep filling the queue
//   until it is full, then s_tready drops.
module packbits_row_decoder_unit #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] body_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] pixel, [23:8] row, [33:24] column, [41:34] copies
	output logic        m_tlast,   // row_end
	output logic [1:0]  m_tuser,   // [0] image_end, [1] overrun
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data
);

	pbrd_pkg::pbrd_cfg_t    cfg_q;
	logic                   q_valid;
	logic                   q_ready;
	pbrd_pkg::pbrd_entry_t  q_entry;
	pbrd_pkg::pbrd_result_t res;

	assign cfg_ready = 1'b1;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 11'd320;
			cfg_q.image_height <= 16'd200;
			cfg_q.compressed   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pbrd_pkg::pbrd_reg_t'(cfg_index))
				pbrd_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[10:0];
				pbrd_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				pbrd_pkg::REG_COMPRESSED:   cfg_q.compressed   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: accept and classify bytes, hold them in a short queue.
	pbrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_entry  (q_entry)
	);

	// Back: advance the row decoder and register each result.
	pbrd_decode #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {6'd0, res.copies, res.column, res.row, res.pixel};
	assign m_tlast = res.row_end;
	assign m_tuser = {res.overrun, res.image_end};

endmodule

@@ tb/tb_packbits_row_decoder_unit.sv @@
// Self-checking testbench for packbits_row_decoder_unit: stream stimulus and pixel write checks.
module tb_packbits_row_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_PIXELS   = 1024;
	localparam int unsigned PHASE_BYTES  = 125;
	localparam int unsigned PHASE_COUNT  = 12;
	// Queue depth plus decoder and output stages, with margin.
	localparam int unsigned QUIET_CYCLES = 16;
	localparam int unsigned LIMIT_CYCLES = 1000000;

	// Tracks the decoder state and the pixel writes it must produce.
	class pixel_write_checker;
		pbrd_pkg::pbrd_cfg_t     cfg;
		pbrd_pkg::pbrd_phase_t   phase;
		logic [7:0]              lit_left;
		logic [7:0]              rep_len;
		logic [10:0]             col_pos;
		logic [15:0]             row_idx;
		pbrd_pkg::pbrd_result_t  due_writes[$];
		int unsigned             mismatches;

		function new();
			cfg.image_width  = 11'd320;
			cfg.image_height = 16'd200;
			cfg.compressed   = 1'b1;
			phase      = pbrd_pkg::PH_HEADER;
			lit_left   = '0;
			rep_len    = '0;
			col_pos    = '0;
			row_idx    = '0;
			mismatches = 0;
		endfunction

		function void set_reg(pbrd_pkg::pbrd_reg_t idx, logic [15:0] value);
			case (idx)
				pbrd_pkg::REG_IMAGE_WIDTH: cfg.image_width = value[10:0];
				pbrd_pkg::REG_IMAGE_HEIGHT: cfg.image_height = value;
				pbrd_pkg::REG_COMPRESSED: cfg.compressed = value[0];
				default: ;
			endcase
		endfunction

		function int unsigned visible_width();
			int unsigned w;
			w = cfg.image_width;
			if (w < 1) w = 1;
			if (w > MAX_PIXELS) w = MAX_PIXELS;
			return w;
		endfunction

		function int unsigned padded_width();
			int unsigned w;
			w = visible_width();
			return w + (w & 1);
		endfunction

		function int unsigned due_count();
			return due_writes.size();
		endfunction

		// Queue a write when it shows pixels or closes the row; advance the row on a close.
		function void post_write(logic [7:0] pix, int unsigned col, int unsigned cnt,
				bit rend, bit ovr);
			int unsigned            rows;
			bit                     iend;
			pbrd_pkg::pbrd_result_t w;
			rows = (cfg.image_height != 0) ? cfg.image_height : 1;
			iend = 1'b0;
			if (!rend && cnt == 0) return;
			if (rend) iend = (int'(row_idx) + 1) >= rows;
			w.pixel     = pix;
			w.row       = row_idx;
			w.column    = (cnt != 0) ? 10'(col) : 10'd0;
			w.copies    = 8'(cnt);
			w.row_end   = rend;
			w.image_end = iend;
			w.overrun   = ovr;
			due_writes.push_back(w);
			if (rend) begin
				col_pos  = '0;
				phase    = pbrd_pkg::PH_HEADER;
				lit_left = '0;
				row_idx  = iend ? 16'd0 : row_idx + 16'd1;
			end
		endfunction

		// Note one accepted body byte and work out the write it causes.
		function void decode_byte(logic [7:0] b);
			int unsigned vis, pad, pos, cnt, start, span;
			bit          past;
			vis = visible_width();
			pad = padded_width();
			pos = col_pos;
			if (!cfg.compressed) begin
				cnt      = (pos < vis) ? 1 : 0;
				phase    = pbrd_pkg::PH_HEADER;
				lit_left = '0;
				if (pos < pad) pos++;
				col_pos = 11'(pos);
				post_write(b, pos - cnt, cnt, pos >= pad, 1'b0);
				return;
			end
			case (phase)
				pbrd_pkg::PH_LITERAL: begin
					cnt   = (pos < vis) ? 1 : 0;
					past  = pos >= pad;
					start = pos;
					if (lit_left > 0) lit_left--;
					if (!past) pos++;
					col_pos = 11'(pos);
					if (lit_left == 0) begin
						phase = pbrd_pkg::PH_HEADER;
						if (past) post_write(b, start, 0, 1'b1, 1'b1);
						else post_write(b, start, cnt, pos >= pad, 1'b0);
					end else begin
						post_write(b, start, cnt, 1'b0, 1'b0);
					end
				end
				pbrd_pkg::PH_REPEAT: begin
					cnt   = 0;
					span  = pos + rep_len;
					phase = pbrd_pkg::PH_HEADER;
					if (pos < vis) begin
						cnt = vis - pos;
						if (cnt > rep_len) cnt = rep_len;
					end
					col_pos = 11'((span < pad) ? span : pad);
					post_write(b, pos, cnt, span >= pad, span > pad);
				end
				default: begin
					if (b >= 8'd1 && b <= 8'd127) begin
						lit_left = b + 8'd1;
						phase    = pbrd_pkg::PH_LITERAL;
					end else begin
						rep_len = (b == 8'd0) ? 8'd1 : 8'(257 - int'(b));
						phase   = pbrd_pkg::PH_REPEAT;
					end
				end
			endcase
		endfunction

		function void field_check(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// Compare one accepted write with the oldest one due.
		function void check_write(pbrd_pkg::pbrd_result_t got);
			pbrd_pkg::pbrd_result_t want;
			if (due_writes.size() == 0) begin
				mismatches++;
				$display("%0t: write with none due, expected nothing, got pixel %0d row %0d col %0d",
					$time, got.pixel, got.row, got.column);
				return;
			end
			want = due_writes.pop_front();
			field_check("pixel", want.pixel, got.pixel);
			field_check("row", want.row, got.row);
			field_check("column", want.column, got.column);
			field_check("copies", want.copies, got.copies);
			field_check("row_end", want.row_end, got.row_end);
			field_check("image_end", want.image_end, got.image_end);
			field_check("overrun", want.overrun, got.overrun);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;   // [7:0] pixel, [23:8] row, [33:24] column, [41:34] copies
	logic        m_tlast;   // row_end
	logic [1:0]  m_tuser;   // [0] image_end, [1] overrun
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index = pbrd_pkg::REG_IMAGE_WIDTH;
	logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	pixel_write_checker sb = new();
	int unsigned bytes_sent = 0;
	int unsigned cycles     = 0;
	bit          steady     = 1'b0;   // set to run a phase with no idling on either side

	packbits_row_decoder_unit #(.MAX_WIDTH(MAX_PIXELS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Bound the run; a hang ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Master side: check each transfer, then pick the next ready level.
	initial begin
		int unsigned            hold;
		int unsigned            g;
		pbrd_pkg::pbrd_result_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.pixel     = m_tdata[7:0];
				got.row       = m_tdata[23:8];
				got.column    = m_tdata[33:24];
				got.copies    = m_tdata[41:34];
				got.row_end   = m_tlast;
				got.image_end = m_tuser[0];
				got.overrun   = m_tuser[1];
				sb.check_write(got);
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				g = idle_len();
				hold = (g > 0) ? g - 1 : 0;
				m_tready <= (g == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Write one register and drop cfg_valid after it; the block must be idle.
	task automatic write_reg(pbrd_pkg::pbrd_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Offer one body byte after a random gap and hold it until the transfer.
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.decode_byte(b);
		bytes_sent++;
	endtask

	// Drop valid, wait for every due write, then let bytes with no write retire.
	task automatic drain_all();
		s_tvalid <= 1'b0;
		while (sb.due_count() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// One row of well-formed runs with random content; some runs overshoot, some noise.
	task automatic send_row(int unsigned pad);
		int          left;
		int unsigned n, r, k;
		left = pad;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_byte(8'($urandom));
			end else if (r < 50) begin
				if ($urandom_range(0, 9) == 0) n = $urandom_range(2, 128);
				else n = $urandom_range(2, (left > 128) ? 128 : ((left < 2) ? 2 : left));
				send_byte(8'(n - 1));
				for (k = 0; k < n; k++) send_byte(8'($urandom));
				left -= n;
			end else begin
				if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 129);
				else n = $urandom_range(1, (left > 129) ? 129 : left);
				send_byte((n == 1) ? 8'h00 : 8'(257 - n));
				send_byte(8'($urandom));
				left -= n;
			end
		end
	endtask

	initial begin
		logic [7:0]  packed_rows[] = '{
			8'h01, 8'h00, 8'hFF,               // two literals
			8'hFF, 8'hAA,                      // repeat 2 closes the row exactly
			8'h02, 8'h01, 8'h02, 8'h03,        // three literals, one short of the row
			8'h03, 8'h10, 8'h20, 8'h30, 8'h40, // literal run past the row: overrun, last row
			8'h80, 8'h55,                      // longest repeat, past the row
			8'h00, 8'h11,                      // zero header: repeat once
			8'hFE, 8'h22                       // repeat reaching the row end exactly
		};
		logic [7:0]  raw_bytes[] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h81};
		logic [15:0] width, height;
		bit          comp;
		int unsigned ph, start;

		// Hold reset, then release on an edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: tiny odd width so every boundary case falls in a few bytes.
		write_reg(pbrd_pkg::REG_IMAGE_WIDTH, 16'd3);
		write_reg(pbrd_pkg::REG_IMAGE_HEIGHT, 16'd2);
		write_reg(pbrd_pkg::REG_COMPRESSED, 16'd1);
		foreach (packed_rows[i]) send_byte(packed_rows[i]);
		drain_all();
		write_reg(pbrd_pkg::REG_COMPRESSED, 16'd0);
		foreach (raw_bytes[i]) send_byte(raw_bytes[i]);

		// Random phases: extremes first, then mostly small widths.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_all();
			case (ph)
				0: begin width = 16'd1024; height = 16'd65535; end
				1: begin width = 16'd0;    height = 16'd0;     end
				2: begin width = 16'd2047; height = 16'd1;     end
				3: begin width = 16'd1;    height = 16'd3;     end
				default: begin
					case ($urandom_range(0, 9))
						0: width = 16'd0;
						1: width = 16'd1;
						2: width = 16'd1023;
						3: width = 16'd2047;
						4: width = 16'($urandom_range(1, 1024));
						default: width = 16'($urandom_range(1, 12));
					endcase
					case ($urandom_range(0, 7))
						0: height = 16'd0;
						1: height = 16'd65535;
						default: height = 16'($urandom_range(1, 6));
					endcase
				end
			endcase
			comp = (ph == 4) ? 1'b0 : ($urandom_range(0, 4) != 0);
			write_reg(pbrd_pkg::REG_IMAGE_WIDTH, width);
			write_reg(pbrd_pkg::REG_IMAGE_HEIGHT, height);
			write_reg(pbrd_pkg::REG_COMPRESSED, {15'd0, comp});
			steady = ($urandom_range(0, 3) == 0);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				if (comp) send_row(sb.padded_width());
				else send_byte(8'($urandom));
			end
		end

		// Wait out every due write and the retire latency, then report.
		drain_all();
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
